/* hw/rtl/qjt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qjt_pkg: shared types and constants
// Widths, reset pose and register indexes for the quintic trajectory block.
// ----------------------------------------------------------------------------
package qjt_pkg;

	localparam int JOINTS    = 7;
	localparam int JIDX_W    = $clog2(JOINTS);
	localparam int POS_W     = 16;
	localparam int ELAPSED_W = 27;
	localparam int DUR_W     = 26;
	localparam int PERIOD_W  = 16;
	localparam int S_W       = 17;              // Q1.16 value in 0..1.0 inclusive
	localparam int DIV_STEPS = 16;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);
	localparam int Q_W       = 20;              // 10 - 15s + 6s^2 in Q16
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_DUR = CFG_IDX_W'(JOINTS);

	localparam logic [S_W-1:0]   ONE_Q16   = S_W'(65536);
	localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(10000000);

	typedef logic signed [POS_W-1:0] pos_t;

	localparam pos_t END_RESET [JOINTS] = '{
		16'sd0, -16'sd3355, 16'sd6730, -16'sd6582, -16'sd9302, 16'sd5894, 16'sd2753
	};

endpackage

/* hw/rtl/quintic_joint_trajectory.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quintic_joint_trajectory: minimum-jerk set-point generator
// Seven-joint quintic interpolator; a start beat latches the start pose, tick
// beats advance time and produce one commanded pose each.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | command, period_us, meas_pos_0..6
//  out     | out_valid / out_ready| cmd_pos_0..6, motion_done
//  cfg     | cfg_valid / cfg_ready| cfg_index (0..6 end pose, 7 duration), cfg_data
//
//  One beat in flight at a time. A start beat goes from idle straight to the
//  output state; a tick past the end of motion passes through evaluation first;
//  an interpolating tick runs the bit-serial divider, the blend multiplies and
//  the lane multiplies, plus sequencing.
//  The result sits in an output register; a stalled out channel holds it and
//  the next finished result waits in the sequencer until the register frees.
//  cfg_ready is always high; writes are expected only while idle.
//  Reset clears elapsed time and start pose and loads the default end pose
//  and a 10 s duration.
// ----------------------------------------------------------------------------
module quintic_joint_trajectory import qjt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 command,
	input  logic [PERIOD_W-1:0]  period_us,
	input  pos_t                 meas_pos_0,
	input  pos_t                 meas_pos_1,
	input  pos_t                 meas_pos_2,
	input  pos_t                 meas_pos_3,
	input  pos_t                 meas_pos_4,
	input  pos_t                 meas_pos_5,
	input  pos_t                 meas_pos_6,

	output logic                 out_valid,
	input  logic                 out_ready,
	output pos_t                 cmd_pos_0,
	output pos_t                 cmd_pos_1,
	output pos_t                 cmd_pos_2,
	output pos_t                 cmd_pos_3,
	output pos_t                 cmd_pos_4,
	output pos_t                 cmd_pos_5,
	output pos_t                 cmd_pos_6,
	output logic                 motion_done,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DUR_W-1:0]     cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EVAL  = 6'b000010,
		S_DIV   = 6'b000100,
		S_BLEND = 6'b001000,
		S_LANE  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	// which pose the pending result is taken from
	typedef enum logic [1:0] {
		RES_START,
		RES_END,
		RES_BLEND
	} res_kind_t;

	state_t    state_q;
	res_kind_t kind_q;

	pos_t                 end_q   [JOINTS];
	pos_t                 start_q [JOINTS];
	logic [DUR_W-1:0]     dur_q;
	logic [ELAPSED_W-1:0] elapsed_q;

	pos_t cmd_q [JOINTS];
	logic done_q;
	logic out_valid_q;

	pos_t                 meas [JOINTS];
	pos_t                 lane_cmd [JOINTS];
	logic [DUR_W-1:0]     dur_eff;
	logic [ELAPSED_W:0]   elapsed_sum;
	logic [ELAPSED_W-1:0] elapsed_nxt;
	logic                 in_fire;
	logic                 out_free;
	logic                 div_start, div_done;
	logic [S_W-1:0]       s_val;
	logic                 blend_start, blend_done;
	logic [S_W-1:0]       blend_val;
	logic                 lane_en;

	assign meas[0] = meas_pos_0;
	assign meas[1] = meas_pos_1;
	assign meas[2] = meas_pos_2;
	assign meas[3] = meas_pos_3;
	assign meas[4] = meas_pos_4;
	assign meas[5] = meas_pos_5;
	assign meas[6] = meas_pos_6;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	// a zero duration behaves as 1 us
	assign dur_eff = (dur_q == '0) ? DUR_W'(1) : dur_q;

	// elapsed time saturates at all ones
	assign elapsed_sum = {1'b0, elapsed_q} + (ELAPSED_W+1)'(period_us);
	assign elapsed_nxt = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];

	assign div_start   = (state_q == S_EVAL) && (elapsed_q <= ELAPSED_W'(dur_eff));
	assign blend_start = (state_q == S_DIV) && div_done;
	assign lane_en     = (state_q == S_BLEND) && blend_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < JOINTS; j++) begin
				end_q[j] <= END_RESET[j];
			end
			dur_q <= DUR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index < CFG_IDX_DUR) begin
				end_q[cfg_index[JIDX_W-1:0]] <= cfg_data[POS_W-1:0];
			end else if (cfg_index == CFG_IDX_DUR) begin
				dur_q <= cfg_data;
			end
		end
	end

	// sequencer and trajectory state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			kind_q    <= RES_START;
			elapsed_q <= '0;
			for (int j = 0; j < JOINTS; j++) begin
				start_q[j] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (command) begin
							for (int j = 0; j < JOINTS; j++) begin
								start_q[j] <= meas[j];
							end
							elapsed_q <= '0;
							kind_q    <= RES_START;
							state_q   <= S_OUT;
						end else begin
							elapsed_q <= elapsed_nxt;
							state_q   <= S_EVAL;
						end
					end
				end
				S_EVAL: begin
					if (div_start) begin
						state_q <= S_DIV;
					end else begin
						kind_q  <= RES_END;
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_BLEND;
					end
				end
				S_BLEND: begin
					if (blend_done) begin
						state_q <= S_LANE;
					end
				end
				S_LANE: begin
					kind_q  <= RES_BLEND;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	qjt_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.elapsed (elapsed_q),
		.dur     (dur_eff),
		.done    (div_done),
		.quot    (s_val)
	);

	qjt_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blend_start),
		.s      (s_val),
		.done   (blend_done),
		.blend  (blend_val)
	);

	for (genvar j = 0; j < JOINTS; j++) begin : g_lane
		qjt_lane u_lane (
			.clk       (clk),
			.en        (lane_en),
			.start_pos (start_q[j]),
			.end_pos   (end_q[j]),
			.blend     (blend_val),
			.cmd       (lane_cmd[j])
		);
	end

	// merge: pick start pose, end pose or lane results into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			for (int j = 0; j < JOINTS; j++) begin
				case (kind_q)
					RES_START: cmd_q[j] <= start_q[j];
					RES_END:   cmd_q[j] <= end_q[j];
					default:   cmd_q[j] <= lane_cmd[j];
				endcase
			end
			done_q <= (kind_q == RES_END);
		end
	end

	assign out_valid   = out_valid_q;
	assign cmd_pos_0   = cmd_q[0];
	assign cmd_pos_1   = cmd_q[1];
	assign cmd_pos_2   = cmd_q[2];
	assign cmd_pos_3   = cmd_q[3];
	assign cmd_pos_4   = cmd_q[4];
	assign cmd_pos_5   = cmd_q[5];
	assign cmd_pos_6   = cmd_q[6];
	assign motion_done = done_q;

endmodule

/* hw/rtl/qjt_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qjt_div: normalized time divider
// Restoring divider, one quotient bit per cycle: s = (elapsed << 16) / dur,
// valid only for elapsed <= dur.
// ----------------------------------------------------------------------------
module qjt_div import qjt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ELAPSED_W-1:0] elapsed,
	input  logic [DUR_W-1:0]     dur,
	output logic                 done,
	output logic [S_W-1:0]       quot
);

	logic [DUR_W-1:0] rem_q;
	logic [S_W-1:0]   quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DUR_W:0]     rem2;
	logic               ge;
	logic [DUR_W:0]     rem_nxt;
	logic               first;
	logic [ELAPSED_W-1:0] first_rem;

	assign rem2    = {rem_q, 1'b0};
	assign ge      = rem2 >= {1'b0, dur};
	assign rem_nxt = ge ? rem2 - {1'b0, dur} : rem2;

	// integer bit: set when elapsed reaches dur, which in the valid range means equal
	assign first     = elapsed >= ELAPSED_W'(dur);
	assign first_rem = first ? elapsed - ELAPSED_W'(dur) : elapsed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= first_rem[DUR_W-1:0];
			quot_q <= {{(S_W-1){1'b0}}, first};
		end else if (busy_q) begin
			rem_q  <= rem_nxt[DUR_W-1:0];
			quot_q <= {quot_q[S_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* hw/rtl/qjt_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qjt_blend: quintic blend polynomial
// Three registered multiply stages: b = min((s^3 * (10 - 15s + 6s^2)) >> 16, 1.0)
// ----------------------------------------------------------------------------
module qjt_blend import qjt_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [S_W-1:0] s,
	output logic           done,
	output logic [S_W-1:0] blend
);

	localparam logic [21:0] Q_TEN = 22'd655360;

	logic           v_s1, v_s2, v_s3;
	logic [S_W-1:0] s_s1, s2_s1;
	logic [S_W-1:0] s3_s2;
	logic [Q_W-1:0] q_s2;
	logic [S_W-1:0] b_s3;

	logic [2*S_W-1:0]   sq;
	logic [2*S_W-1:0]   cube;
	logic [21:0]        s15, s2x6, q_full;
	logic [S_W+Q_W-1:0] bq;
	logic [S_W+Q_W-17:0] b_sh;

	assign sq   = s * s;
	assign cube = s2_s1 * s_s1;
	assign s15  = (22'(s_s1) << 4) - 22'(s_s1);
	assign s2x6 = (22'(s2_s1) << 2) + (22'(s2_s1) << 1);
	// wraps modulo 2^22; true value fits as a signed number
	assign q_full = Q_TEN - s15 + s2x6;
	assign bq     = s3_s2 * q_s2;
	assign b_sh   = bq[S_W+Q_W-1:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		s_s1  <= s;
		s2_s1 <= sq[32:16];
		s3_s2 <= cube[32:16];
		q_s2  <= q_full[21] ? '0 : q_full[Q_W-1:0];
		b_s3  <= (b_sh > (S_W+Q_W-16)'(ONE_Q16)) ? ONE_Q16 : b_sh[S_W-1:0];
	end

	assign done  = v_s3;
	assign blend = b_s3;

endmodule

/* hw/rtl/qjt_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qjt_lane: one joint interpolator
// cmd = start + floor((end - start) * b / 2^16), product registered.
// ----------------------------------------------------------------------------
module qjt_lane import qjt_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  pos_t           start_pos,
	input  pos_t           end_pos,
	input  logic [S_W-1:0] blend,
	output pos_t           cmd
);

	logic signed [POS_W:0]        diff;
	logic signed [POS_W+S_W+1:0]  prod_s1;
	logic signed [POS_W+2:0]      step;
	logic signed [POS_W+2:0]      sum;

	assign diff = $signed({end_pos[POS_W-1], end_pos}) -
	              $signed({start_pos[POS_W-1], start_pos});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= diff * $signed({1'b0, blend});
		end
	end

	assign step = prod_s1[POS_W+S_W+1:16];    // arithmetic shift, floors
	assign sum  = step + $signed({{3{start_pos[POS_W-1]}}, start_pos});
	assign cmd  = sum[POS_W-1:0];

endmodule

/* hw/rtl/qjt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qjt_checker: port-level checks
// Watches the trajectory block's channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module qjt_checker import qjt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input pos_t cmd_pos_0,
	input logic motion_done,
	input logic cfg_ready
);

	// one beat in flight: accepting a beat closes the input channel
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted back to back");

	// a new result only appears after a beat was being worked on
	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without a beat in flight");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cmd_pos_0) && $stable(motion_done))
		else $error("stalled result changed");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> cfg_ready)
		else $error("config port closed while idle");

endmodule

bind quintic_joint_trajectory qjt_checker u_qjt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.cmd_pos_0   (cmd_pos_0),
	.motion_done (motion_done),
	.cfg_ready   (cfg_ready)
);

/* verif/quintic_joint_trajectory_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quintic_joint_trajectory_tb: self-checking bench for the min-jerk generator
// Drives start and tick beats through the input channel and register writes
// through the config channel. A built-in setpoint predictor computes the
// expected pose per beat, and every output beat is compared joint by joint.
// ----------------------------------------------------------------------------
module quintic_joint_trajectory_tb;
	import qjt_pkg::*;

	// Beat kinds on the command bit
	typedef enum logic {
		CMD_TICK  = 1'b0,
		CMD_START = 1'b1
	} traj_cmd_e;

	typedef logic [JOINTS-1:0][POS_W-1:0] joint_vec_t;

	typedef struct packed {
		traj_cmd_e               cmd;
		logic [PERIOD_W-1:0]     period;
		joint_vec_t              meas;
	} traj_item_t;

	typedef struct packed {
		logic                    done;
		joint_vec_t              pos;
	} pose_t;

	// End pose registers sit at 0..JOINTS-1, duration right after them.
	// Anything above the duration index must be dropped by the block.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_END0  = '0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_DUR + 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_BAD   = '1;

	localparam logic [DUR_W-1:0] DUR_MAX     = '1;
	localparam pos_t             POS_MIN     = 16'sh8000;
	localparam pos_t             POS_MAX     = 16'sh7FFF;
	localparam longint           UNIT_Q16    = 65536;
	localparam longint unsigned  ELAPSED_SAT = (64'd1 << ELAPSED_W) - 1;

	// Watchdog bound, kept with a wide margin over the slowest legal run
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int TAIL_CYCLES = 30;
	localparam int RAND_ITEMS  = 350;
	localparam int COAST_TICKS = 1150;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;

	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic                 command   = 1'b0;
	logic [PERIOD_W-1:0]  period_us = '0;
	pos_t                 meas_pos_0 = '0;
	pos_t                 meas_pos_1 = '0;
	pos_t                 meas_pos_2 = '0;
	pos_t                 meas_pos_3 = '0;
	pos_t                 meas_pos_4 = '0;
	pos_t                 meas_pos_5 = '0;
	pos_t                 meas_pos_6 = '0;

	logic                 out_valid;
	logic                 out_ready = 1'b0;
	pos_t                 cmd_pos_0;
	pos_t                 cmd_pos_1;
	pos_t                 cmd_pos_2;
	pos_t                 cmd_pos_3;
	pos_t                 cmd_pos_4;
	pos_t                 cmd_pos_5;
	pos_t                 cmd_pos_6;
	logic                 motion_done;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DUR_W-1:0]     cfg_data  = '0;

	quintic_joint_trajectory uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.period_us   (period_us),
		.meas_pos_0  (meas_pos_0),
		.meas_pos_1  (meas_pos_1),
		.meas_pos_2  (meas_pos_2),
		.meas_pos_3  (meas_pos_3),
		.meas_pos_4  (meas_pos_4),
		.meas_pos_5  (meas_pos_5),
		.meas_pos_6  (meas_pos_6),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cmd_pos_0   (cmd_pos_0),
		.cmd_pos_1   (cmd_pos_1),
		.cmd_pos_2   (cmd_pos_2),
		.cmd_pos_3   (cmd_pos_3),
		.cmd_pos_4   (cmd_pos_4),
		.cmd_pos_5   (cmd_pos_5),
		.cmd_pos_6   (cmd_pos_6),
		.motion_done (motion_done),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Setpoint predictor: own copy of the registers and the trajectory state
	// ------------------------------------------------------------------------
	pos_t                 plan_end_pose   [JOINTS];
	pos_t                 plan_start_pose [JOINTS];
	logic [DUR_W-1:0]     plan_dur_us;
	logic [ELAPSED_W-1:0] plan_elapsed_us;

	initial begin
		for (int j = 0; j < JOINTS; j++) begin
			plan_end_pose[j]   = END_RESET[j];
			plan_start_pose[j] = '0;
		end
		plan_dur_us     = DUR_RESET;
		plan_elapsed_us = '0;
	end

	// Advances the trajectory by one input beat and returns the pose it yields
	function automatic pose_t next_setpoint(traj_item_t it);
		pose_t           r;
		longint unsigned dur, s, s2, s3, sum;
		longint          q, blend, diff, cmd;
		r = '0;
		// a zero duration behaves like 1 us
		dur = (plan_dur_us == 0) ? 64'd1 : 64'(plan_dur_us);
		if (it.cmd == CMD_START) begin
			for (int j = 0; j < JOINTS; j++)
				plan_start_pose[j] = pos_t'(it.meas[j]);
			plan_elapsed_us = '0;
			r.pos = it.meas;
			return r;
		end
		// elapsed time clamps at its all-ones value instead of wrapping
		sum = 64'(plan_elapsed_us) + 64'(it.period);
		plan_elapsed_us = (sum > ELAPSED_SAT) ? ELAPSED_SAT[ELAPSED_W-1:0] :
			sum[ELAPSED_W-1:0];
		if (64'(plan_elapsed_us) <= dur) begin
			// s in Q1.16, blend = s^3 * (10 - 15s + 6s^2), all floors
			s  = (64'(plan_elapsed_us) << 16) / dur;
			s2 = (s * s) >> 16;
			s3 = (s2 * s) >> 16;
			q  = 10 * UNIT_Q16 - 15 * longint'(s) + 6 * longint'(s2);
			if (q < 0)
				q = 0;
			blend = longint'((s3 * longint'(q)) >> 16);
			if (blend > UNIT_Q16)
				blend = UNIT_Q16;
			for (int j = 0; j < JOINTS; j++) begin
				diff = longint'(plan_end_pose[j]) - longint'(plan_start_pose[j]);
				cmd  = longint'(plan_start_pose[j]) + ((diff * blend) >>> 16);
				r.pos[j] = cmd[POS_W-1:0];
			end
		end else begin
			// past the end of motion: hold the target
			for (int j = 0; j < JOINTS; j++)
				r.pos[j] = plan_end_pose[j];
			r.done = 1'b1;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Shared bookkeeping
	// ------------------------------------------------------------------------
	traj_item_t pending_beats [$];
	pose_t      setpoint_q    [$];
	traj_item_t cur_beat;

	int  n_queued     = 0;
	int  n_accepted   = 0;
	int  n_starts     = 0;
	int  n_results    = 0;
	int  n_done       = 0;
	int  n_cfg_writes = 0;
	int  errors       = 0;
	int  cycle_cnt    = 0;
	int  gap_left     = 0;
	int  stall_left   = 0;
	bit  src_idle_on  = 1'b1;
	bit  sink_idle_on = 1'b1;

	function automatic int draw_wait(bit on);
		return on ? int'($urandom_range(0, 19)) : 0;
	endfunction

	// Extremes show up often so the sign and saturation corners get hit
	function automatic pos_t rand_pos();
		case ($urandom_range(0, 7))
			0:       return POS_MIN;
			1:       return POS_MAX;
			default: return pos_t'($urandom);
		endcase
	endfunction

	function automatic joint_vec_t rand_pose();
		joint_vec_t p;
		for (int j = 0; j < JOINTS; j++)
			p[j] = rand_pos();
		return p;
	endfunction

	// Ticks carry a random pose and starts a random period: both are don't-care
	function automatic traj_item_t tick_beat(int unsigned period);
		traj_item_t it;
		it.cmd    = CMD_TICK;
		it.period = PERIOD_W'(period);
		it.meas   = rand_pose();
		return it;
	endfunction

	function automatic traj_item_t start_beat(joint_vec_t pose);
		traj_item_t it;
		it.cmd    = CMD_START;
		it.period = PERIOD_W'($urandom);
		it.meas   = pose;
		return it;
	endfunction

	task automatic queue_beat(traj_item_t it);
		pending_beats.push_back(it);
		n_queued++;
	endtask

	// Register write; the predictor copy follows the decode of the block
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_cfg_writes++;
		if (idx < JOINTS)
			plan_end_pose[idx] = pos_t'(data[POS_W-1:0]);
		else if (idx == CFG_IDX_DUR)
			plan_dur_us = data;
	endtask

	// Upper data bits are junk on purpose: end pose writes use the low 16 only
	task automatic set_end_pose(int j, pos_t v);
		write_reg(CFG_IDX_W'(CFG_IDX_END0 + j), {(DUR_W - POS_W)'($urandom), v});
	endtask

	// Every beat yields exactly one result, so nothing queued, nothing
	// accepted-but-unanswered means the block has gone quiet
	task automatic wait_idle();
		while (n_accepted != n_queued || setpoint_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Input driver: pops pending beats, holds each until accepted, then
	// inserts the drawn gap before the next one
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : beat_source
		traj_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				setpoint_q.push_back(next_setpoint(cur_beat));
				n_accepted++;
				if (cur_beat.cmd == CMD_START)
					n_starts++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_beats.size() != 0) begin
					nxt = pending_beats.pop_front();
					cur_beat   <= nxt;
					command    <= nxt.cmd;
					period_us  <= nxt.period;
					meas_pos_0 <= nxt.meas[0];
					meas_pos_1 <= nxt.meas[1];
					meas_pos_2 <= nxt.meas[2];
					meas_pos_3 <= nxt.meas[3];
					meas_pos_4 <= nxt.meas[4];
					meas_pos_5 <= nxt.meas[5];
					meas_pos_6 <= nxt.meas[6];
					in_valid   <= 1'b1;
					gap_left   <= draw_wait(src_idle_on);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output monitor: checks each result beat against the oldest expected
	// pose, then stalls for a drawn number of cycles that only count down
	// while a result is actually waiting
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_sink
		pose_t got, want;
		int    hold;
		if (!arst_n) begin
			out_ready  <= 1'b1;
			stall_left <= 0;
		end else if (out_valid && out_ready) begin
			got.done = motion_done;
			got.pos  = {cmd_pos_6, cmd_pos_5, cmd_pos_4, cmd_pos_3,
				cmd_pos_2, cmd_pos_1, cmd_pos_0};
			n_results++;
			if (got.done)
				n_done++;
			if (setpoint_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with no pose expected", $time);
			end else begin
				want = setpoint_q.pop_front();
				for (int j = 0; j < JOINTS; j++)
					if (got.pos[j] !== want.pos[j]) begin
						errors++;
						$display("%0t: cmd_pos_%0d expected %0d, got %0d", $time, j,
							$signed(want.pos[j]), $signed(got.pos[j]));
					end
				if (got.done !== want.done) begin
					errors++;
					$display("%0t: motion_done expected %0b, got %0b", $time,
						want.done, got.done);
				end
			end
			hold = draw_wait(sink_idle_on);
			out_ready  <= (hold == 0);
			stall_left <= hold;
		end else if (!out_ready && out_valid) begin
			out_ready  <= (stall_left <= 1);
			stall_left <= (stall_left > 0) ? stall_left - 1 : 0;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("quintic_joint_trajectory_tb: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus: directed corners, a long coast past the longest duration,
	// then random trajectories under random register settings
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int          n_rand;
		int          n_tick;
		int unsigned dur, dur_eff, step, period;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ticks before any start: interpolate away from the all-zero pose
		// toward the reset target over the reset duration
		queue_beat(tick_beat(0));
		queue_beat(tick_beat(16'hFFFF));
		wait_idle();

		// Full-scale swing over 1000 us: midpoint, exact end, just past it
		for (int j = 0; j < JOINTS; j++)
			set_end_pose(j, POS_MAX);
		write_reg(CFG_IDX_DUR, 26'd1000);
		queue_beat(start_beat({JOINTS{POS_MIN}}));
		queue_beat(tick_beat(0));
		queue_beat(tick_beat(250));
		queue_beat(tick_beat(250));
		queue_beat(tick_beat(500));
		queue_beat(tick_beat(1));
		queue_beat(tick_beat(16'hFFFF));
		// start already at the target: zero swing
		queue_beat(start_beat({JOINTS{POS_MAX}}));
		queue_beat(tick_beat(500));
		wait_idle();

		// Zero duration is treated as 1 us; writes to unused indexes must
		// not disturb it (all-ones data would read as a huge duration)
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		for (int j = 0; j < JOINTS; j++)
			set_end_pose(j, POS_MIN);
		write_reg(CFG_IDX_DUR, '0);
		write_reg(CFG_IDX_SPARE, '1);
		write_reg(CFG_IDX_BAD, '1);
		queue_beat(start_beat({JOINTS{POS_MAX}}));
		queue_beat(tick_beat(0));
		queue_beat(tick_beat(1));
		queue_beat(tick_beat(1));
		wait_idle();

		// Longest duration, mixed target
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		for (int j = 0; j < JOINTS; j++)
			set_end_pose(j, rand_pos());
		write_reg(CFG_IDX_DUR, DUR_MAX);
		queue_beat(start_beat(rand_pose()));
		queue_beat(tick_beat(16'hFFFF));
		queue_beat(tick_beat(16'hFFFF));
		queue_beat(tick_beat(0));
		wait_idle();

		// Coast: long ticks with no restart run elapsed time through the
		// longest duration, after which the target must hold
		src_idle_on  = $urandom_range(0, 1);
		sink_idle_on = $urandom_range(0, 1);
		queue_beat(start_beat(rand_pose()));
		for (int k = 0; k < COAST_TICKS; k++)
			queue_beat(tick_beat($urandom_range(60000, 65535)));
		wait_idle();

		// Random trajectories: mostly start + ticks sized to sweep the move,
		// with stray restarts and odd periods mixed in
		n_rand = 0;
		while (n_rand < RAND_ITEMS) begin
			for (int j = 0; j < JOINTS; j++)
				if ($urandom_range(0, 3) != 0)
					set_end_pose(j, rand_pos());
			case ($urandom_range(0, 9))
				0:       dur = 0;
				1:       dur = 1;
				2:       dur = DUR_MAX;
				3, 4:    dur = $urandom_range(5000, 1000000);
				default: dur = $urandom_range(1, 5000);
			endcase
			write_reg(CFG_IDX_DUR, DUR_W'(dur));
			if ($urandom_range(0, 7) == 0)
				write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE : CFG_IDX_BAD, DUR_W'($urandom));
			src_idle_on  = ($urandom_range(0, 3) != 0);
			sink_idle_on = ($urandom_range(0, 3) != 0);

			dur_eff = (dur == 0) ? 1 : dur;
			n_tick  = $urandom_range(5, 40);
			// aim a little past the end so most moves finish and then hold
			step = dur_eff * 5 / (4 * n_tick) + 1;
			if (step > 65535)
				step = 65535;
			queue_beat(start_beat(rand_pose()));
			n_rand++;
			for (int k = 0; k < n_tick; k++) begin
				case ($urandom_range(0, 19))
					0:       queue_beat(start_beat(rand_pose()));
					1:       queue_beat(tick_beat(0));
					2:       queue_beat(tick_beat(16'hFFFF));
					3:       queue_beat(tick_beat($urandom_range(0, 65535)));
					default: begin
						period = $urandom_range(step / 2, step + step / 2);
						queue_beat(tick_beat((period > 65535) ? 65535 : period));
					end
				endcase
				n_rand++;
			end
			wait_idle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run covered %0d input beats (%0d starts) and %0d result beats, %0d at end of motion",
			n_accepted, n_starts, n_results, n_done);
		$display("%0d register writes across directed and random settings, %0d mismatches",
			n_cfg_writes, errors);
		if (errors == 0)
			$display("quintic_joint_trajectory_tb: clean");
		else
			$display("quintic_joint_trajectory_tb: errors");
		$finish;
	end

endmodule

/* quintic_joint_trajectory.f */
hw/rtl/qjt_pkg.sv
hw/rtl/qjt_div.sv
hw/rtl/qjt_blend.sv
hw/rtl/qjt_lane.sv
hw/rtl/quintic_joint_trajectory.sv
hw/rtl/qjt_checker.sv
verif/quintic_joint_trajectory_tb.sv
